// ===== sv/srlp_pkg.sv =====
// Shared types and constants for the SMTP reply line parser.
// No dependencies; imported by srlp_line_core and smtp_reply_line_parser.
`timescale 1ns / 1ps
`default_nettype none

package srlp_pkg;

  localparam int MAX_LINE_DEFAULT = 1024;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam logic [9:0] EHLO_CODE = 10'd250;
  localparam logic [9:0] CODE_MAX  = 10'd999;

  localparam logic       OP_DATA  = 1'b0;
  localparam logic       OP_CLOSE = 1'b1;

  // Keyword matcher codes: 0..7 are the index of the next expected letter.
  localparam logic [3:0] KW_LEN  = 4'd8;
  localparam logic [3:0] KW_CR   = 4'd9;
  localparam logic [3:0] KW_FAIL = 4'd15;

  typedef enum logic [1:0] {
    ST_CONT   = 2'd0,
    ST_DONE   = 2'd1,
    ST_ERROR  = 2'd2,
    ST_CLOSED = 2'd3
  } status_t;

  typedef struct packed {
    logic       fire;
    status_t    status;
    logic [9:0] code;
    logic       tls;
    logic       done;
  } result_t;

  // Lower-case letters of the STARTTLS keyword.
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h73; // s
      3'd1:    c = 8'h74; // t
      3'd2:    c = 8'h61; // a
      3'd3:    c = 8'h72; // r
      3'd4:    c = 8'h74; // t
      3'd5:    c = 8'h74; // t
      3'd6:    c = 8'h6C; // l
      default: c = 8'h73; // s
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/srlp_line_core.sv =====
// Per-byte line and answer state of the SMTP reply parser.
// Uses srlp_pkg; instantiated by smtp_reply_line_parser.
`timescale 1ns / 1ps
`default_nettype none

module srlp_line_core import srlp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic       opcode,
  input  wire logic [7:0] rx_byte,
  input  wire logic       reply_mode,
  output result_t         res
);

  localparam int POS_W = $clog2(MAX_LINE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

  logic [POS_W-1:0] line_position, line_position_next;
  logic [9:0]       line_code, line_code_next;
  logic             code_format_bad, code_format_bad_next;
  logic             continuation_mark, continuation_mark_next;
  logic [3:0]       kw_state, kw_state_next;
  logic [9:0]       answer_code, answer_code_next;
  logic             first_line_pending, first_line_pending_next;
  logic             starttls_seen, starttls_seen_next;

  logic       is_digit;
  logic       kw_match;
  logic       line_bad;
  logic       tls_now;
  logic [9:0] code_times_ten;

  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign kw_match = (kw_state == KW_LEN) || (kw_state == KW_CR);
  assign code_times_ten = {line_code[6:0], 3'b000} + {line_code[8:0], 1'b0};
  assign tls_now = starttls_seen | kw_match;

  always_comb begin
    line_position_next      = line_position;
    line_code_next          = line_code;
    code_format_bad_next    = code_format_bad;
    continuation_mark_next  = continuation_mark;
    kw_state_next           = kw_state;
    answer_code_next        = answer_code;
    first_line_pending_next = first_line_pending;
    starttls_seen_next      = starttls_seen;
    res        = '0;
    res.status = ST_CONT;
    line_bad   = 1'b0;

    if (opcode == OP_CLOSE) begin
      res.fire   = 1'b1;
      res.status = ST_CLOSED;
      res.done   = 1'b1;
    end else if (rx_byte == CHAR_LF) begin
      line_bad = (line_position < POS_W'(3)) || code_format_bad;
      if (!line_bad) begin
        if (reply_mode) begin
          line_bad = (line_code != EHLO_CODE);
        end else begin
          line_bad = !first_line_pending && (answer_code != line_code);
        end
      end
      res.fire = 1'b1;
      if (line_bad) begin
        res.status = ST_ERROR;
        res.done   = 1'b1;
      end else begin
        res.code = line_code;
        res.tls  = reply_mode & tls_now;
        if (continuation_mark) begin
          res.status = ST_CONT;
          if (first_line_pending && !reply_mode) begin
            answer_code_next = line_code;
          end
          first_line_pending_next = 1'b0;
          starttls_seen_next      = reply_mode ? tls_now : starttls_seen;
        end else begin
          res.status = ST_DONE;
          res.done   = 1'b1;
        end
      end
    end else if (line_position >= POS_LAST) begin
      // The line has no room left for anything but its LF.
      res.fire   = 1'b1;
      res.status = ST_ERROR;
      res.done   = 1'b1;
    end else begin
      line_position_next = line_position + POS_W'(1);
      if (line_position < POS_W'(3)) begin
        if (is_digit) begin
          line_code_next = code_times_ten + {6'd0, rx_byte[3:0]};
        end else begin
          code_format_bad_next = 1'b1;
        end
      end else if (line_position == POS_W'(3)) begin
        if (is_digit) begin
          code_format_bad_next = 1'b1;
        end
        if (rx_byte == CHAR_DASH) begin
          continuation_mark_next = 1'b1;
        end
      end else begin
        if (kw_state < KW_LEN) begin
          kw_state_next = ((rx_byte | CASE_BIT) == kw_char(kw_state[2:0])) ?
                          kw_state + 4'd1 : KW_FAIL;
        end else if (kw_state == KW_LEN) begin
          if (rx_byte == CHAR_SPACE) begin
            kw_state_next = KW_LEN;
          end else if (rx_byte == CHAR_CR) begin
            kw_state_next = KW_CR;
          end else begin
            kw_state_next = KW_FAIL;
          end
        end else begin
          kw_state_next = KW_FAIL;
        end
      end
    end

    // Any finished line clears the line state; an ended answer clears all.
    if (res.fire) begin
      line_position_next     = '0;
      line_code_next         = '0;
      code_format_bad_next   = 1'b0;
      continuation_mark_next = 1'b0;
      kw_state_next          = '0;
    end
    if (res.fire && res.done) begin
      answer_code_next        = '0;
      first_line_pending_next = 1'b1;
      starttls_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position      <= '0;
      line_code          <= '0;
      code_format_bad    <= 1'b0;
      continuation_mark  <= 1'b0;
      kw_state           <= '0;
      answer_code        <= '0;
      first_line_pending <= 1'b1;
      starttls_seen      <= 1'b0;
    end else if (go) begin
      line_position      <= line_position_next;
      line_code          <= line_code_next;
      code_format_bad    <= code_format_bad_next;
      continuation_mark  <= continuation_mark_next;
      kw_state           <= kw_state_next;
      answer_code        <= answer_code_next;
      first_line_pending <= first_line_pending_next;
      starttls_seen      <= starttls_seen_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    line_position <= POS_LAST)
    else $error("line position beyond the last byte slot");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    line_code <= CODE_MAX)
    else $error("line code above three digits");

  a_kw_after_code: assert property (@(posedge clk) disable iff (rst)
    (kw_state != 4'd0) |-> (line_position >= POS_W'(5)))
    else $error("keyword matcher moved inside the code field");

  a_answer_cleared: assert property (@(posedge clk) disable iff (rst)
    (go && res.fire && res.done) |=> (first_line_pending && !starttls_seen))
    else $error("answer state not cleared after an ended answer");

endmodule

`default_nettype wire

// ===== sv/smtp_reply_line_parser.sv =====
// SMTP reply line parser: input request register, line core, result register.
// Throughput: one byte per cycle; the input stage stalls only while the result
// register holds an untaken result. Synchronous active-high reset clears all
// control and parser state and sets reply_mode to generic. Uses srlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smtp_reply_line_parser import srlp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       reply_mode,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic [9:0]      reply_code,
  output logic            has_starttls,
  output logic            answer_done
);

  logic       mode;
  logic       s1_valid;
  logic       s1_opcode;
  logic [7:0] s1_byte;
  logic       s1_go;
  logic       in_take;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_go;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= reply_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode <= opcode;
      s1_byte   <= rx_byte;
    end
  end

  srlp_line_core #(
    .MAX_LINE(MAX_LINE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (s1_go),
    .opcode    (s1_opcode),
    .rx_byte   (s1_byte),
    .reply_mode(mode),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_go && res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.fire) begin
      status       <= res.status;
      reply_code   <= res.code;
      has_starttls <= res.tls;
      answer_done  <= res.done;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_byte) && $stable(s1_opcode)))
    else $error("waiting request lost or changed");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(reply_code)))
    else $error("stalled result dropped");

endmodule

`default_nettype wire
